>>> rtl/xmac_pkg.sv
// Shared types, constants and helpers for the X-MAC preamble-sampling controller.
package xmac_pkg;

   localparam int QUEUE_DEPTH_DEF   = 16;
   localparam int HEADER_BYTES_DEF  = 5;
   localparam int PULSE_SAMPLES_DEF = 5;
   localparam int ADDR_BITS_DEF     = 16;

   localparam logic [63:0] PULSE_TIME_NS      = 64'd450000;
   localparam logic [63:0] ACK_TIMEOUT_NS     = 64'd100000000;
   localparam logic [63:0] ACK_DELTA_NS       = 64'd1000;
   localparam logic [63:0] BCAST_WAIT_EXTRA_NS = 64'd10000000;

   typedef enum logic [1:0] {
      CMD_TIMER   = 2'd0,
      CMD_ENQUEUE = 2'd1,
      CMD_RECEIVE = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   localparam logic [2:0] RX_PREAMBLE = 3'd0;
   localparam logic [2:0] RX_DATA     = 3'd1;
   localparam logic [2:0] RX_DACK     = 3'd2;
   localparam logic [2:0] RX_PACK     = 3'd3;

   localparam logic [1:0] TX_PREAMBLE = 2'd0;
   localparam logic [1:0] TX_DATA     = 2'd1;
   localparam logic [1:0] TX_DACK     = 2'd2;
   localparam logic [1:0] TX_PACK     = 2'd3;

   localparam logic [1:0] ST_NONE    = 2'd0;
   localparam logic [1:0] ST_DONE    = 2'd1;
   localparam logic [1:0] ST_DROPPED = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam logic [2:0] CSR_NODE_ID    = 3'd0;
   localparam logic [2:0] CSR_FEATURES   = 3'd1;
   localparam logic [2:0] CSR_MAX_RETRY  = 3'd2;
   localparam logic [2:0] CSR_BUSY_THR   = 3'd3;
   localparam logic [2:0] CSR_INIT_BO    = 3'd4;
   localparam logic [2:0] CSR_CONG_BO    = 3'd5;
   localparam logic [2:0] CSR_CHECK_INT  = 3'd6;
   localparam logic [2:0] CSR_BIT_TIME   = 3'd7;

   typedef enum logic [3:0] {
      S_PDOWN    = 4'd0,
      S_PULSE    = 4'd1,
      S_IDLE     = 4'd2,
      S_PRETX    = 4'd3,
      S_PREAMBLE = 4'd4,
      S_TX       = 4'd5,
      S_TXING    = 4'd6,
      S_WAITACK  = 4'd7,
      S_WAITDATA = 4'd8,
      S_DACK     = 4'd9,
      S_DACKEND  = 4'd10,
      S_PACK     = 4'd11,
      S_UNUSED12 = 4'd12,
      S_UNUSED13 = 4'd13,
      S_UNUSED14 = 4'd14,
      S_UNUSED15 = 4'd15
   } mac_state_type;

   // Configuration as seen by the event engine.
   typedef struct packed {
      logic [15:0] node_id;
      logic [1:0]  features;
      logic [7:0]  max_retries;
      logic [7:0]  busy_thr;
      logic [31:0] init_bo;
      logic [31:0] cong_bo;
      logic [31:0] check_int;
      logic [19:0] bit_time;
      logic [63:0] strobe;
      logic [63:0] hdr_time;
   } cfg_type;

   function automatic logic positive(input logic [63:0] v);
      positive = (v != 64'd0) && !v[63];
   endfunction

endpackage

>>> rtl/xmac_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module xmac_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> rtl/xmac_cfg.sv
// Configuration registers and the derived strobe and header times.
module xmac_cfg
   import xmac_pkg::*;
#(
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output cfg_type     cfg
);
   localparam logic [63:0] HDR_BITS = 64'(HEADER_BYTES * 8);

   logic [15:0] node_id_ff;
   logic [1:0]  features_ff;
   logic [7:0]  max_retries_ff;
   logic [7:0]  busy_thr_ff;
   logic [31:0] init_bo_ff, cong_bo_ff, check_int_ff;
   logic [19:0] bit_time_ff;
   logic [63:0] hdr_time;

   // Header time is a multiply by a constant, so it follows bit time at once.
   assign hdr_time = HDR_BITS * {44'd0, bit_time_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff     <= 16'd0;
         features_ff    <= 2'd3;
         max_retries_ff <= 8'd2;
         busy_thr_ff    <= 8'hB6;
         init_bo_ff     <= 32'd5000000;
         cong_bo_ff     <= 32'd5000000;
         check_int_ff   <= 32'd100000000;
         bit_time_ff    <= 20'd4000;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_NODE_ID:   node_id_ff     <= csr_wdata[15:0];
               CSR_FEATURES:  features_ff    <= csr_wdata[1:0];
               CSR_MAX_RETRY: max_retries_ff <= csr_wdata[7:0];
               CSR_BUSY_THR:  busy_thr_ff    <= csr_wdata[7:0];
               CSR_INIT_BO:   init_bo_ff     <= csr_wdata;
               CSR_CONG_BO:   cong_bo_ff     <= csr_wdata;
               CSR_CHECK_INT: check_int_ff   <= csr_wdata;
               CSR_BIT_TIME:  bit_time_ff    <= csr_wdata[19:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      cfg.node_id     = node_id_ff;
      cfg.features    = features_ff;
      cfg.max_retries = max_retries_ff;
      cfg.busy_thr    = busy_thr_ff;
      cfg.init_bo     = init_bo_ff;
      cfg.cong_bo     = cong_bo_ff;
      cfg.check_int   = check_int_ff;
      cfg.bit_time    = bit_time_ff;
      cfg.hdr_time    = hdr_time;
      cfg.strobe      = (check_int_ff == 32'd0) ? 64'd0 : hdr_time;
   end
endmodule

>>> rtl/xmac_preamble_sampling_mac.sv
// Top level of the X-MAC preamble-sampling controller: event engine and frame queue.
//
//  channel | ports       | payload
//  --------+-------------+------------------------------------------------------
//  request | req_t*      | tdata: now_time, frame_dst, frame_src, frame_bytes,
//          |             |        carrier_sense_dbm, noise_dbm; tuser: command, rx_type
//  result  | rsp_t*      | tdata: send_type, send_dst, send_bytes, wake_time,
//          |             |        mac_state; tuser: send_frame, deliver_up,
//          |             |        radio_power, wake_armed, tx_status
//  config  | csr_*       | index 0..7, data 32 bits
//
// One request per cycle unless the result register is full and not taken or a
// pop waits for the prefetch: the engine updates all state in the accept cycle.
// The only memory is the frame queue; its head entry is kept prefetched in a
// registered read port, refreshed after any head or write change. A timer event
// that pops the queue in the cycle after an enqueue or pop waits for the prefetch
// (ready low). Reset is synchronous; the queue needs no clearing pass. A stalled
// result register holds and blocks only when full and not being taken.
module xmac_preamble_sampling_mac
   import xmac_pkg::*;
#(
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
   parameter int HEADER_BYTES  = HEADER_BYTES_DEF,
   parameter int PULSE_SAMPLES = PULSE_SAMPLES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // [63:0] now_time, [79:64] frame_dst, [95:80] frame_src,
   // [111:96] frame_bytes, [119:112] carrier_sense_dbm, [127:120] noise_dbm
   input  logic [127:0]  req_tdata,
   // [1:0] command, [4:2] rx_type
   input  logic [4:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [1:0] send_type, [17:2] send_dst, [33:18] send_bytes,
   // [97:34] wake_time, [101:98] mac_state
   output logic [103:0]  rsp_tdata,
   // [0] send_frame, [1] deliver_up, [2] radio_power, [3] wake_armed,
   // [5:4] tx_status
   output logic [5:0]    rsp_tuser,
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_wdata
);
   localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QC = $clog2(QUEUE_DEPTH + 1);
   localparam logic [15:0] BCAST   = 16'hFFFF;
   localparam logic [15:0] HDR_LEN = 16'(HEADER_BYTES);
   localparam logic [2:0]  PULSE_MAX = 3'(PULSE_SAMPLES);

   cfg_type cfg;

   xmac_cfg #(.HEADER_BYTES(HEADER_BYTES)) u_cfg (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata, .cfg
   );

   // Request fields.
   logic [63:0] now;
   logic [15:0] fdst, fsrc, fbytes;
   logic [7:0]  cs_dbm, nz_dbm;
   cmd_type     cmd;
   logic [2:0]  rtype;
   assign now    = req_tdata[63:0];
   assign fdst   = req_tdata[79:64];
   assign fsrc   = req_tdata[95:80];
   assign fbytes = req_tdata[111:96];
   assign cs_dbm = req_tdata[119:112];
   assign nz_dbm = req_tdata[127:120];
   assign cmd    = cmd_type'(req_tuser[1:0]);
   assign rtype  = req_tuser[4:2];

   // State registers.
   mac_state_type st_ff, st_in;
   logic        rtp_ff, rtp_in, radio_ff, radio_in, pend_ff, pend_in;
   logic        cvalid_ff, cvalid_in, srcv_ff, srcv_in, tgtv_ff, tgtv_in;
   logic [63:0] sched_ff, sched_in, bstart_ff, bstart_in, bleft_ff, bleft_in;
   logic [63:0] pspent_ff, pspent_in;
   logic [2:0]  pulse_ff, pulse_in;
   logic [7:0]  retry_ff, retry_in;
   logic [31:0] cur_ff, cur_in;
   logic [15:0] dpeer_ff, dpeer_in, apeer_ff, apeer_in, srca_ff, srca_in;
   logic [15:0] tgta_ff, tgta_in;
   logic [QA-1:0] head_ff, head_in;
   logic [QC-1:0] count_ff, count_in;
   logic        fresh_ff;   // head prefetch valid

   // Queue memory.
   logic          q_we;
   logic [QA-1:0] q_waddr;
   logic [31:0]   q_rdata;
   logic [QA:0]   q_wsum;

   assign q_wsum  = {1'b0, head_ff} + (QA+1)'(count_ff);
   assign q_waddr = (q_wsum >= (QA+1)'(QUEUE_DEPTH)) ?
                    QA'(q_wsum - (QA+1)'(QUEUE_DEPTH)) : q_wsum[QA-1:0];

   xmac_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .wr_en(q_we), .wr_addr(q_waddr), .wr_data({fbytes, fdst}),
      .rd_addr(head_in), .rd_data(q_rdata)
   );

   // Result register.
   logic        out_full_ff;
   logic [103:0] out_data_ff;
   logic [5:0]   out_user_ff;
   logic         take, need_pop_read, stall_pop;

   assign need_pop_read = (cmd == CMD_TIMER) && pend_ff && (now == sched_ff) &&
                          (st_ff == S_IDLE) && !cvalid_ff && (count_ff != '0);
   assign stall_pop  = need_pop_read && !fresh_ff;
   assign req_tready = (!out_full_ff || rsp_tready) && !stall_pop;
   assign take       = req_tvalid && req_tready;

   // Event engine.
   logic        send, deliver;
   logic [1:0]  stype, status;
   logic [15:0] sdst, sbytes;
   logic        busy, addr_hit, cca, acks;
   logic [63:0] bl_tmp, bs_tmp;

   assign cca  = cfg.features[0];
   assign acks = cfg.features[1];
   assign busy = ($signed(cs_dbm) >= $signed(cfg.busy_thr)) ||
                 ($signed(nz_dbm) >= $signed(cfg.busy_thr));
   assign addr_hit = (fdst == cfg.node_id) || (fdst == BCAST);

   always_comb begin
      st_in = st_ff; rtp_in = rtp_ff; radio_in = radio_ff; pend_in = pend_ff;
      cvalid_in = cvalid_ff; srcv_in = srcv_ff; tgtv_in = tgtv_ff;
      sched_in = sched_ff; bstart_in = bstart_ff; bleft_in = bleft_ff;
      pspent_in = pspent_ff; pulse_in = pulse_ff; retry_in = retry_ff;
      cur_in = cur_ff; dpeer_in = dpeer_ff; apeer_in = apeer_ff;
      srca_in = srca_ff; tgta_in = tgta_ff; head_in = head_ff; count_in = count_ff;
      send = 1'b0; deliver = 1'b0; stype = TX_PREAMBLE; sdst = 16'd0;
      sbytes = 16'd0; status = ST_NONE; q_we = 1'b0;
      bl_tmp = 64'd0; bs_tmp = 64'd0;
      if (take) begin
         unique case (cmd)
            CMD_ENQUEUE: begin
               if (count_ff >= QC'(QUEUE_DEPTH)) begin
                  status = ST_FULL;
               end else begin
                  q_we = 1'b1;
                  count_in = count_ff + 1'b1;
                  // Wake from power down; idle only rearms the timer.
                  if (st_ff == S_PDOWN) begin
                     st_in = S_IDLE; radio_in = 1'b1;
                  end
                  if (st_ff == S_PDOWN || st_ff == S_IDLE) begin
                     sched_in = now; pend_in = 1'b1;
                  end
               end
            end
            CMD_RECEIVE: begin
               if (rtype == RX_PREAMBLE && st_ff == S_PULSE && rtp_ff) begin
                  bstart_in = now; bleft_in = {32'd0, cfg.cong_bo};
                  rtp_in = 1'b0; st_in = S_PRETX;
                  sched_in = now + {32'd0, cfg.cong_bo}; pend_in = 1'b1;
               end
               if (addr_hit) begin
                  priority case (rtype)
                     RX_PREAMBLE: begin
                        if (st_in == S_IDLE || st_in == S_PRETX || st_in == S_PULSE) begin
                           if (positive(bleft_in))
                              bleft_in = bleft_in - (now - bstart_in);
                           srcv_in = 1'b1; srca_in = fsrc; pend_in = 1'b1;
                           if (fdst != BCAST) begin
                              st_in = S_PACK; sched_in = now + ACK_DELTA_NS;
                           end else begin
                              st_in = S_WAITDATA;
                              sched_in = now + {32'd0, cfg.check_int} +
                                         BCAST_WAIT_EXTRA_NS;
                           end
                        end
                     end
                     RX_DATA: begin
                        if (st_ff == S_WAITDATA || st_ff == S_PULSE ||
                            cfg.check_int == 32'd0) begin
                           pend_in = 1'b1;
                           if (acks && fdst != BCAST) begin
                              apeer_in = fsrc; st_in = S_DACK;
                              sched_in = now + ACK_DELTA_NS;
                           end else begin
                              if (!positive(bleft_ff)) bleft_in = 64'd0;
                              else bstart_in = now;
                              st_in = S_PRETX;
                              sched_in = now + (positive(bleft_ff) ? bleft_ff : 64'd0);
                           end
                           deliver = 1'b1;
                        end
                     end
                     RX_DACK: begin
                        if (st_ff == S_WAITACK && dpeer_ff == fsrc) begin
                           dpeer_in = 16'd0; st_in = S_IDLE; cvalid_in = 1'b0;
                           bleft_in = 64'd0; bstart_in = 64'd0; retry_in = 8'd1;
                           status = ST_DONE; sched_in = now; pend_in = 1'b1;
                        end
                     end
                     RX_PACK: begin
                        if (st_ff == S_PREAMBLE && tgtv_ff && tgta_ff == fsrc) begin
                           tgtv_in = 1'b0; pspent_in = 64'd0; st_in = S_TX;
                           sched_in = now; pend_in = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            CMD_TIMER: begin
               if (pend_ff && now == sched_ff) begin
                  pend_in = 1'b0;
                  unique case (st_ff)
                     S_IDLE: begin
                        if (!cvalid_ff && count_ff != '0) begin
                           cur_in = q_rdata; cvalid_in = 1'b1;
                           head_in = (head_ff == QA'(QUEUE_DEPTH - 1)) ? '0 :
                                     head_ff + 1'b1;
                           count_in = count_ff - 1'b1;
                        end
                        if (!cvalid_in) begin
                           if (cfg.check_int != 32'd0) begin
                              st_in = S_PDOWN; radio_in = 1'b0; pend_in = 1'b1;
                              sched_in = now + {32'd0, cfg.check_int};
                           end
                        end else begin
                           bstart_in = now; pend_in = 1'b1;
                           if (cca) begin
                              bleft_in = {32'd0, cfg.init_bo}; st_in = S_PRETX;
                              sched_in = now + {32'd0, cfg.init_bo};
                           end else begin
                              bleft_in = 64'd0; sched_in = now;
                              st_in = (cfg.check_int == 32'd0) ? S_TX : S_PREAMBLE;
                           end
                        end
                     end
                     S_PRETX: begin
                        pend_in = 1'b1;
                        if (!cvalid_ff) begin
                           bleft_in = 64'd0; bstart_in = 64'd0; st_in = S_IDLE;
                           sched_in = now;
                        end else begin
                           bl_tmp = positive(bleft_ff) ?
                                    bleft_ff - (now - bstart_ff) : bleft_ff;
                           bleft_in = bl_tmp;
                           if (positive(bl_tmp)) begin
                              sched_in = now + bl_tmp;
                           end else begin
                              st_in = S_PULSE; rtp_in = 1'b1; pulse_in = 3'd1;
                              sched_in = now + {cfg.strobe[61:0], 2'b00};
                           end
                        end
                     end
                     S_PDOWN: begin
                        radio_in = 1'b1; st_in = S_PULSE; pulse_in = 3'd1;
                        pend_in = 1'b1; sched_in = now + {cfg.strobe[61:0], 2'b00};
                     end
                     S_PULSE: begin
                        pend_in = 1'b1;
                        if (!busy) begin
                           if (rtp_ff) begin
                              bstart_in = now; bleft_in = 64'd0; rtp_in = 1'b0;
                              st_in = (cfg.check_int == 32'd0) ? S_TX : S_PREAMBLE;
                              sched_in = now;
                           end else begin
                              if (!positive(bleft_ff)) bleft_in = 64'd0;
                              else bstart_in = now;
                              st_in = S_PRETX;
                              sched_in = now + (positive(bleft_ff) ? bleft_ff : 64'd0);
                           end
                        end else if (pulse_ff < PULSE_MAX) begin
                           pulse_in = pulse_ff + 3'd1; sched_in = now + PULSE_TIME_NS;
                        end else begin
                           st_in = S_PRETX;
                           if (rtp_ff) begin
                              bstart_in = now; bleft_in = {32'd0, cfg.cong_bo};
                              rtp_in = 1'b0; sched_in = now + {32'd0, cfg.cong_bo};
                           end else begin
                              sched_in = now;
                           end
                        end
                     end
                     S_PREAMBLE: begin
                        if (pspent_ff <= {32'd0, cfg.check_int} + cfg.strobe +
                                         {cfg.strobe[62:0], 1'b0}) begin
                           if (cvalid_ff) begin
                              bs_tmp = cfg.strobe + {cfg.strobe[62:0], 1'b0};
                              tgtv_in = 1'b1; tgta_in = cur_ff[15:0];
                              send = 1'b1; stype = TX_PREAMBLE; sdst = cur_ff[15:0];
                              sbytes = HDR_LEN; pspent_in = pspent_ff + bs_tmp;
                              pend_in = 1'b1; sched_in = now + bs_tmp;
                           end
                        end else begin
                           pspent_in = 64'd0; tgtv_in = 1'b0; st_in = S_TX;
                           pend_in = 1'b1; sched_in = now;
                        end
                     end
                     S_TX: begin
                        if (cvalid_ff) begin
                           send = 1'b1; stype = TX_DATA; sdst = cur_ff[15:0];
                           sbytes = cur_ff[31:16]; st_in = S_TXING;
                           dpeer_in = cur_ff[15:0]; pend_in = 1'b1;
                           // bytes*8*bit_time: 16x20 product plus a shift
                           sched_in = now + {25'd0, (36'(cur_ff[31:16]) *
                                      36'(cfg.bit_time)), 3'd0};
                        end
                     end
                     S_TXING: begin
                        pend_in = 1'b1;
                        if (acks && dpeer_ff != BCAST) begin
                           st_in = S_WAITACK; sched_in = now + ACK_TIMEOUT_NS;
                        end else begin
                           cvalid_in = 1'b0; bleft_in = 64'd0; bstart_in = 64'd0;
                           status = ST_DONE; st_in = S_IDLE; sched_in = now;
                        end
                     end
                     S_WAITACK: begin
                        if (retry_ff >= cfg.max_retries) begin
                           retry_in = 8'd1; cvalid_in = 1'b0; bleft_in = 64'd0;
                           bstart_in = 64'd0; status = ST_DROPPED;
                        end else begin
                           retry_in = retry_ff + 8'd1;
                        end
                        st_in = S_IDLE; pend_in = 1'b1; sched_in = now;
                     end
                     S_PACK: begin
                        send = 1'b1; stype = TX_PACK; sbytes = HDR_LEN;
                        sdst = srcv_ff ? srca_ff : BCAST; st_in = S_WAITDATA;
                        pend_in = 1'b1;
                        sched_in = now + cfg.hdr_time + {32'd0, cfg.check_int};
                     end
                     S_DACK: begin
                        send = 1'b1; stype = TX_DACK; sbytes = HDR_LEN;
                        sdst = apeer_ff; apeer_in = 16'd0; st_in = S_DACKEND;
                        pend_in = 1'b1; sched_in = now + cfg.hdr_time;
                     end
                     S_DACKEND, S_WAITDATA: begin
                        if (st_ff == S_WAITDATA) srcv_in = 1'b0;
                        if (!positive(bleft_ff)) bleft_in = 64'd0;
                        else bstart_in = now;
                        st_in = S_PRETX; pend_in = 1'b1;
                        sched_in = now + (positive(bleft_ff) ? bleft_ff : 64'd0);
                     end
                     default: pend_in = 1'b1;
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; rtp_ff <= 1'b0; radio_ff <= 1'b1; pend_ff <= 1'b0;
         cvalid_ff <= 1'b0; srcv_ff <= 1'b0; tgtv_ff <= 1'b0;
         sched_ff <= 64'd0; bstart_ff <= 64'd0; bleft_ff <= 64'd0;
         pspent_ff <= 64'd0; pulse_ff <= 3'd1; retry_ff <= 8'd1;
         cur_ff <= 32'd0; dpeer_ff <= 16'd0; apeer_ff <= 16'd0;
         srca_ff <= 16'd0; tgta_ff <= 16'd0; head_ff <= '0; count_ff <= '0;
         fresh_ff <= 1'b0; out_full_ff <= 1'b0;
      end else begin
         st_ff <= st_in; rtp_ff <= rtp_in; radio_ff <= radio_in; pend_ff <= pend_in;
         cvalid_ff <= cvalid_in; srcv_ff <= srcv_in; tgtv_ff <= tgtv_in;
         sched_ff <= sched_in; bstart_ff <= bstart_in; bleft_ff <= bleft_in;
         pspent_ff <= pspent_in; pulse_ff <= pulse_in; retry_ff <= retry_in;
         cur_ff <= cur_in; dpeer_ff <= dpeer_in; apeer_ff <= apeer_in;
         srca_ff <= srca_in; tgta_ff <= tgta_in; head_ff <= head_in;
         count_ff <= count_in;
         // Prefetch is stale after any write or pop; it refreshes next cycle.
         fresh_ff <= !(q_we || (head_in != head_ff));
         if (take) out_full_ff <= 1'b1;
         else if (rsp_tready) out_full_ff <= 1'b0;
      end
      if (take) begin
         out_data_ff <= {2'b00, st_in, (pend_in ? sched_in : 64'd0), sbytes,
                         sdst, stype};
         out_user_ff <= {status, pend_in, radio_in, deliver, send};
      end
   end

   assign rsp_tvalid = out_full_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
endmodule

>>> tb/testbench.sv
// Testbench for the X-MAC preamble-sampling controller: event predictor and stream checks.
module testbench;
   import xmac_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HDR_BYTES = 5;
   localparam int PULSES = 5;
   localparam logic [15:0] BCAST = 16'hFFFF;

   // How the driver fills in the time stamp and the source at drive time.
   typedef enum logic [1:0] {STAMP_FIXED, STAMP_WAKE, STAMP_RECENT} stamp_mode_type;
   typedef enum logic [1:0] {SRC_FIXED, SRC_TARGET, SRC_DATA_PEER} src_mode_type;

   typedef struct {
      cmd_type        cmd;
      logic [2:0]     rx_type;
      logic [63:0]    now;
      logic [15:0]    dst;
      logic [15:0]    src;
      logic [15:0]    bytes;
      logic [7:0]     sense;
      logic [7:0]     noise;
      stamp_mode_type stamp;
      src_mode_type   src_mode;
   } mac_request;

   typedef struct {
      logic          send;
      logic [1:0]    send_type;
      logic [15:0]   send_dst;
      logic [15:0]   send_bytes;
      logic          deliver;
      logic          radio;
      logic          armed;
      logic [63:0]   wake;
      logic [1:0]    status;
      mac_state_type state;
   } mac_result;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [127:0]  req_tdata;
   logic [4:0]    req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [103:0]  rsp_tdata;
   logic [5:0]    rsp_tuser;
   logic          csr_we;
   logic [2:0]    csr_index;
   logic [31:0]   csr_wdata;

   xmac_preamble_sampling_mac DUT (.*);

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   // Predictor copy of the configuration.
   logic [15:0]        cf_node;
   logic [1:0]         cf_feat;
   logic [7:0]         cf_retries;
   logic signed [7:0]  cf_thr;
   logic [31:0]        cf_init_bo, cf_cong_bo, cf_check;
   logic [19:0]        cf_bit;

   // Predictor copy of the controller state.
   mac_state_type mc_state;
   logic          mc_back_pretx, mc_radio, mc_pending, mc_cur_valid;
   logic          mc_src_valid, mc_tgt_valid;
   logic [63:0]   mc_sched, mc_bo_start, mc_bo_left, mc_pre_spent;
   logic [2:0]    mc_pulse;
   logic [7:0]    mc_retry;
   logic [31:0]   mc_cur_frame;
   logic [15:0]   mc_data_peer, mc_ack_peer, mc_src_addr, mc_tgt_addr;
   logic [31:0]   mc_fifo [16];
   logic [3:0]    mc_head;
   logic [4:0]    mc_count;
   logic [63:0]   last_now;

   mac_request    pending_requests[$];
   mac_result     expected_results[$];
   mac_request    driven;
   logic          req_took;
   int            send_idle_pct, rsp_stall_pct;
   int            errors;

   function automatic logic still_owed(input logic [63:0] v);
      return v != 64'd0 && !v[63];
   endfunction

   task automatic arm_wake(input logic [63:0] t);
      mc_sched = t;
      mc_pending = 1'b1;
   endtask

   task automatic halt_backoff(input logic [63:0] now);
      if (still_owed(mc_bo_left)) mc_bo_left = mc_bo_left - (now - mc_bo_start);
   endtask

   task automatic resume_pretx(input logic [63:0] now);
      if (!still_owed(mc_bo_left)) mc_bo_left = 64'd0;
      else mc_bo_start = now;
      mc_state = S_PRETX;
      arm_wake(now + mc_bo_left);
   endtask

   task automatic drop_frame();
      mc_cur_valid = 1'b0;
      mc_bo_left = 64'd0;
      mc_bo_start = 64'd0;
   endtask

   task automatic reset_model();
      cf_node = 16'd0; cf_feat = 2'd3; cf_retries = 8'd2; cf_thr = -8'sd74;
      cf_init_bo = 32'd5000000; cf_cong_bo = 32'd5000000;
      cf_check = 32'd100000000; cf_bit = 20'd4000;
      mc_state = S_IDLE; mc_back_pretx = 1'b0; mc_radio = 1'b1;
      mc_pending = 1'b0; mc_cur_valid = 1'b0; mc_src_valid = 1'b0;
      mc_tgt_valid = 1'b0; mc_sched = '0; mc_bo_start = '0; mc_bo_left = '0;
      mc_pre_spent = '0; mc_pulse = 3'd1; mc_retry = 8'd1; mc_cur_frame = '0;
      mc_data_peer = '0; mc_ack_peer = '0; mc_src_addr = '0; mc_tgt_addr = '0;
      mc_head = '0; mc_count = '0; last_now = '0;
   endtask

   // Advance the predicted controller by one accepted request.
   task automatic predict_event(input mac_request rq, output mac_result r);
      logic [63:0] now, strobe, hdr_time, check;
      logic cca, acks, busy;
      now = rq.now;
      check = 64'(cf_check);
      hdr_time = 64'(HDR_BYTES * 8) * 64'(cf_bit);
      strobe = (cf_check == 0) ? 64'd0 : hdr_time;
      cca = cf_feat[0];
      acks = cf_feat[1];
      r = '{default: '0, state: S_PDOWN};
      last_now = now;
      if (rq.cmd == CMD_ENQUEUE) begin
         if (mc_count >= 5'd16) begin
            r.status = ST_FULL;
         end else begin
            mc_fifo[4'(mc_head + mc_count)] = {rq.bytes, rq.dst};
            mc_count++;
            if (mc_state == S_PDOWN) begin
               mc_state = S_IDLE;
               mc_radio = 1'b1;
            end
            if (mc_state == S_IDLE) arm_wake(now);
         end
      end else if (rq.cmd == CMD_RECEIVE) begin
         // An overheard preamble during a send-side channel check backs off.
         if (rq.rx_type == RX_PREAMBLE && mc_state == S_PULSE && mc_back_pretx) begin
            mc_bo_start = now;
            mc_bo_left = 64'(cf_cong_bo);
            mc_back_pretx = 1'b0;
            mc_state = S_PRETX;
            arm_wake(now + 64'(cf_cong_bo));
         end
         if (rq.dst == cf_node || rq.dst == BCAST) begin
            case (rq.rx_type)
               RX_PREAMBLE: begin
                  if (mc_state == S_IDLE || mc_state == S_PRETX || mc_state == S_PULSE) begin
                     halt_backoff(now);
                     mc_src_valid = 1'b1;
                     mc_src_addr = rq.src;
                     if (rq.dst != BCAST) begin
                        mc_state = S_PACK;
                        arm_wake(now + ACK_DELTA_NS);
                     end else begin
                        mc_state = S_WAITDATA;
                        arm_wake(now + check + BCAST_WAIT_EXTRA_NS);
                     end
                  end
               end
               RX_DATA: begin
                  if (mc_state == S_WAITDATA || mc_state == S_PULSE || cf_check == 0) begin
                     if (acks && rq.dst != BCAST) begin
                        mc_ack_peer = rq.src;
                        mc_state = S_DACK;
                        arm_wake(now + ACK_DELTA_NS);
                     end else begin
                        resume_pretx(now);
                     end
                     r.deliver = 1'b1;
                  end
               end
               RX_DACK: begin
                  if (mc_state == S_WAITACK && mc_data_peer == rq.src) begin
                     mc_data_peer = '0;
                     mc_state = S_IDLE;
                     drop_frame();
                     mc_retry = 8'd1;
                     r.status = ST_DONE;
                     arm_wake(now);
                  end
               end
               RX_PACK: begin
                  if (mc_state == S_PREAMBLE && mc_tgt_valid && mc_tgt_addr == rq.src) begin
                     mc_tgt_valid = 1'b0;
                     mc_pre_spent = '0;
                     mc_state = S_TX;
                     arm_wake(now);
                  end
               end
               default: ;
            endcase
         end
      end else if (rq.cmd == CMD_TIMER && mc_pending && now == mc_sched) begin
         mc_pending = 1'b0;
         case (mc_state)
            S_IDLE: begin
               if (!mc_cur_valid && mc_count > 0) begin
                  mc_cur_frame = mc_fifo[mc_head];
                  mc_head++;
                  mc_count--;
                  mc_cur_valid = 1'b1;
               end
               if (!mc_cur_valid) begin
                  if (cf_check != 0) begin
                     mc_state = S_PDOWN;
                     mc_radio = 1'b0;
                     arm_wake(now + check);
                  end
               end else begin
                  mc_bo_start = now;
                  if (cca) begin
                     mc_bo_left = 64'(cf_init_bo);
                     mc_state = S_PRETX;
                     arm_wake(now + 64'(cf_init_bo));
                  end else begin
                     mc_bo_left = '0;
                     mc_state = (cf_check == 0) ? S_TX : S_PREAMBLE;
                     arm_wake(now);
                  end
               end
            end
            S_PRETX: begin
               if (!mc_cur_valid) begin
                  mc_bo_left = '0;
                  mc_bo_start = '0;
                  mc_state = S_IDLE;
                  arm_wake(now);
               end else begin
                  halt_backoff(now);
                  if (still_owed(mc_bo_left)) begin
                     arm_wake(now + mc_bo_left);
                  end else begin
                     mc_state = S_PULSE;
                     mc_back_pretx = 1'b1;
                     mc_pulse = 3'd1;
                     arm_wake(now + 64'd4 * strobe);
                  end
               end
            end
            S_PDOWN: begin
               mc_radio = 1'b1;
               mc_state = S_PULSE;
               mc_pulse = 3'd1;
               arm_wake(now + 64'd4 * strobe);
            end
            S_PULSE: begin
               busy = $signed(rq.sense) >= cf_thr || $signed(rq.noise) >= cf_thr;
               if (!busy) begin
                  if (mc_back_pretx) begin
                     mc_bo_start = now;
                     mc_bo_left = '0;
                     mc_state = (cf_check == 0) ? S_TX : S_PREAMBLE;
                     mc_back_pretx = 1'b0;
                     arm_wake(now);
                  end else begin
                     resume_pretx(now);
                  end
               end else if (mc_pulse < PULSES) begin
                  mc_pulse++;
                  arm_wake(now + PULSE_TIME_NS);
               end else begin
                  mc_state = S_PRETX;
                  if (mc_back_pretx) begin
                     mc_bo_start = now;
                     mc_bo_left = 64'(cf_cong_bo);
                     mc_back_pretx = 1'b0;
                     arm_wake(now + 64'(cf_cong_bo));
                  end else begin
                     arm_wake(now);
                  end
               end
            end
            S_PREAMBLE: begin
               if (mc_pre_spent <= check + strobe + 64'd2 * strobe) begin
                  // Without a current frame, hold state and leave the timer off.
                  if (mc_cur_valid) begin
                     mc_tgt_valid = 1'b1;
                     mc_tgt_addr = mc_cur_frame[15:0];
                     r.send = 1'b1;
                     r.send_type = TX_PREAMBLE;
                     r.send_dst = mc_tgt_addr;
                     r.send_bytes = 16'(HDR_BYTES);
                     mc_pre_spent = mc_pre_spent + 64'd3 * strobe;
                     arm_wake(now + 64'd3 * strobe);
                  end
               end else begin
                  mc_pre_spent = '0;
                  mc_tgt_valid = 1'b0;
                  mc_state = S_TX;
                  arm_wake(now);
               end
            end
            S_TX: begin
               if (mc_cur_valid) begin
                  r.send = 1'b1;
                  r.send_type = TX_DATA;
                  r.send_dst = mc_cur_frame[15:0];
                  r.send_bytes = mc_cur_frame[31:16];
                  mc_state = S_TXING;
                  mc_data_peer = r.send_dst;
                  arm_wake(now + 64'(r.send_bytes) * 64'd8 * 64'(cf_bit));
               end
            end
            S_TXING: begin
               if (acks && mc_data_peer != BCAST) begin
                  mc_state = S_WAITACK;
                  arm_wake(now + ACK_TIMEOUT_NS);
               end else begin
                  drop_frame();
                  r.status = ST_DONE;
                  mc_state = S_IDLE;
                  arm_wake(now);
               end
            end
            S_WAITACK: begin
               if (mc_retry >= cf_retries) begin
                  mc_retry = 8'd1;
                  drop_frame();
                  r.status = ST_DROPPED;
               end else begin
                  mc_retry++;
               end
               mc_state = S_IDLE;
               arm_wake(now);
            end
            S_PACK: begin
               r.send = 1'b1;
               r.send_type = TX_PACK;
               r.send_bytes = 16'(HDR_BYTES);
               // An unknown preamble source gets the ack at the broadcast address.
               r.send_dst = mc_src_valid ? mc_src_addr : BCAST;
               mc_state = S_WAITDATA;
               arm_wake(now + hdr_time + check);
            end
            S_DACK: begin
               r.send = 1'b1;
               r.send_type = TX_DACK;
               r.send_bytes = 16'(HDR_BYTES);
               r.send_dst = mc_ack_peer;
               mc_ack_peer = '0;
               mc_state = S_DACKEND;
               arm_wake(now + hdr_time);
            end
            S_DACKEND: resume_pretx(now);
            S_WAITDATA: begin
               mc_src_valid = 1'b0;
               resume_pretx(now);
            end
            default: ;
         endcase
      end
      r.radio = mc_radio;
      r.armed = mc_pending;
      r.wake = mc_pending ? mc_sched : 64'd0;
      r.state = mc_state;
   endtask

   function automatic int check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v, act_v);
         return 1;
      end
      return 0;
   endfunction

   // Driver: present requests at the falling edge, resolving time stamps and
   // peer addresses from the predicted state of that moment.
   always @(negedge clock) begin
      mac_request rq;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_took) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               rq = pending_requests.pop_front();
               if (rq.stamp == STAMP_WAKE) rq.now = mc_pending ? mc_sched : last_now;
               else if (rq.stamp == STAMP_RECENT) rq.now = last_now + $urandom_range(2000);
               if (rq.src_mode == SRC_TARGET) rq.src = mc_tgt_addr;
               else if (rq.src_mode == SRC_DATA_PEER) rq.src = mc_data_peer;
               driven <= rq;
               req_tdata <= {rq.noise, rq.sense, rq.bytes, rq.src, rq.dst, rq.now};
               req_tuser <= {rq.rx_type, rq.cmd};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= $urandom_range(99) >= rsp_stall_pct;
      end
   end

   // Monitor: predict on every accepted request, check every accepted result.
   always @(posedge clock) begin
      mac_result r, exp_r;
      mac_result act;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            predict_event(driven, r);
            expected_results.push_back(r);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result with no request outstanding, tdata %0h", $realtime,
                        rsp_tdata);
               errors++;
            end else begin
               exp_r = expected_results.pop_front();
               act.send_type = rsp_tdata[1:0];
               act.send_dst = rsp_tdata[17:2];
               act.send_bytes = rsp_tdata[33:18];
               act.wake = rsp_tdata[97:34];
               act.state = mac_state_type'(rsp_tdata[101:98]);
               errors += check_field("send_frame", exp_r.send, rsp_tuser[0]);
               errors += check_field("deliver_up", exp_r.deliver, rsp_tuser[1]);
               errors += check_field("radio_power", exp_r.radio, rsp_tuser[2]);
               errors += check_field("wake_armed", exp_r.armed, rsp_tuser[3]);
               errors += check_field("tx_status", exp_r.status, rsp_tuser[5:4]);
               errors += check_field("send_type", exp_r.send_type, act.send_type);
               errors += check_field("send_dst", exp_r.send_dst, act.send_dst);
               errors += check_field("send_bytes", exp_r.send_bytes, act.send_bytes);
               errors += check_field("wake_time", exp_r.wake, act.wake);
               errors += check_field("mac_state", exp_r.state, act.state);
            end
         end
      end
   end

   function automatic mac_request make_request(input cmd_type cmd, input logic [2:0] rx,
                                               input logic [15:0] dst, input logic [15:0] bytes);
      mac_request rq;
      rq.cmd = cmd; rq.rx_type = rx; rq.dst = dst; rq.bytes = bytes;
      rq.now = '0; rq.src = 16'($urandom);
      rq.sense = -8'($urandom_range(128)); rq.noise = -8'($urandom_range(128));
      rq.stamp = (cmd == CMD_TIMER) ? STAMP_WAKE : STAMP_RECENT;
      rq.src_mode = SRC_FIXED;
      return rq;
   endfunction

   // Mostly timers at the armed time so the machine walks deep, with
   // enqueues, receives aimed at this node and some noise.
   function automatic mac_request random_request();
      mac_request rq;
      int pick, dpick;
      logic [15:0] dst;
      pick = $urandom_range(99);
      dpick = $urandom_range(9);
      dst = (dpick < 5) ? cf_node : (dpick < 7) ? BCAST : 16'($urandom);
      if (pick < 55) begin
         rq = make_request(CMD_TIMER, 3'($urandom_range(4)), dst, 16'($urandom));
      end else if (pick < 60) begin
         rq = make_request(CMD_TIMER, 3'($urandom_range(4)), dst, 16'($urandom));
         rq.stamp = STAMP_FIXED;
         rq.now = {$urandom, $urandom};
      end else if (pick < 75) begin
         rq = make_request(CMD_ENQUEUE, 3'($urandom_range(4)), dst,
                           ($urandom_range(9) == 0) ? 16'($urandom_range(65535, 1))
                                                    : 16'($urandom_range(64, 1)));
      end else begin
         rq = make_request(CMD_RECEIVE, 3'($urandom_range(4)), dst, 16'($urandom));
         if (rq.rx_type == RX_PACK) rq.src_mode = SRC_TARGET;
         else if (rq.rx_type == RX_DACK) rq.src_mode = SRC_DATA_PEER;
      end
      return rq;
   endfunction

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_NODE_ID:   cf_node = val[15:0];
         CSR_FEATURES:  cf_feat = val[1:0];
         CSR_MAX_RETRY: cf_retries = val[7:0];
         CSR_BUSY_THR:  cf_thr = val[7:0];
         CSR_INIT_BO:   cf_init_bo = val;
         CSR_CONG_BO:   cf_cong_bo = val;
         CSR_CHECK_INT: cf_check = val;
         CSR_BIT_TIME:  cf_bit = val[19:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_all(input logic [15:0] node, input logic [1:0] feat,
                            input logic [7:0] retries, input logic [7:0] thr,
                            input logic [31:0] ibo, input logic [31:0] cbo,
                            input logic [31:0] chk, input logic [19:0] bt);
      write_csr(CSR_NODE_ID, 32'(node));
      write_csr(CSR_FEATURES, 32'(feat));
      write_csr(CSR_MAX_RETRY, 32'(retries));
      write_csr(CSR_BUSY_THR, 32'(thr));
      write_csr(CSR_INIT_BO, ibo);
      write_csr(CSR_CONG_BO, cbo);
      write_csr(CSR_CHECK_INT, chk);
      write_csr(CSR_BIT_TIME, 32'(bt));
   endtask

   // Drain: every request taken and every result back, then a short hold.
   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (pending_requests.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (10) @(posedge clock);
   endtask

   initial begin
      int phase;
      errors = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      req_took = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset_model();
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: fill the queue past full with extreme frames, then walk the
      // machine and throw every received type at it.
      write_all(16'd7, 2'd3, 8'd2, -8'sd74, 32'd5000000, 32'd5000000,
                32'd100000000, 20'd4000);
      for (int i = 0; i < 17; i++)
         pending_requests.push_back(make_request(CMD_ENQUEUE, RX_PREAMBLE,
            (i == 0) ? 16'd0 : (i == 1) ? BCAST : 16'd7,
            (i == 0) ? 16'd1 : (i == 1) ? 16'hFFFF : 16'(i)));
      for (int i = 0; i < 5; i++) begin
         mac_request rq;
         rq = make_request(CMD_RECEIVE, 3'(i), (i == 4) ? BCAST : 16'd7, 16'd3);
         if (i == 3) rq.src_mode = SRC_TARGET;
         pending_requests.push_back(rq);
         rq = make_request(CMD_TIMER, RX_PREAMBLE, 16'd0, 16'd0);
         rq.sense = (i[0]) ? 8'h80 : 8'hFF;
         rq.noise = (i[0]) ? 8'h00 : 8'h80;
         pending_requests.push_back(rq);
      end
      wait_drained();

      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: write_all(16'd0, 2'd3, 8'd2, -8'sd74, 32'd5000000, 32'd5000000,
                         32'd100000000, 20'd4000);
            1: write_all(16'd300, 2'd0, 8'd1, -8'sd60, 32'd0, 32'd1000, 32'd50000, 20'd1);
            2: write_all(16'd12, 2'd2, 8'd3, -8'sd90, 32'd2000, 32'd3000, 32'd0, 20'd10);
            3: write_all(16'd65534, 2'd3, 8'd255, -8'sd128, 32'hFFFFFFFF, 32'hFFFFFFFF,
                         32'hFFFFFFFF, 20'd1000000);
            4: write_all(16'd5, 2'd1, 8'd4, 8'sd0, 32'd100, 32'd0, 32'd20000, 20'd2);
            5: write_all(16'd40000, 2'd3, 8'd1, -8'sd50, 32'd7000, 32'd9000, 32'd0, 20'd1);
            6: write_all(16'd9, 2'd2, 8'd2, -8'sd100, 32'd0, 32'd500, 32'd1, 20'd3);
            default: write_all(16'd1, 2'd3, 8'd3, -8'sd74, 32'd5000000, 32'd5000000,
                               32'd100000000, 20'd4000);
         endcase
         send_idle_pct = (phase % 4 == 1) ? 61 : (phase % 4 == 3) ? 28 : 0;
         rsp_stall_pct = (phase % 4 == 2) ? 61 : (phase % 4 == 3) ? 28 : 0;
         for (int i = 0; i < 135; i++) pending_requests.push_back(random_request());
         wait_drained();
      end

      if (errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
